### hdl/vdb_pkg.sv
// ----------------------------------------------------------------------------
// vdb_pkg: shared constants for the vector distance and bearing block
// Fixed-point formats, default parameter values and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vdb_pkg;

  localparam int ITERATIONS_DEFAULT  = 16;
  localparam int COORD_WIDTH_DEFAULT = 15;

  // at most this many CORDIC stages are built
  localparam int MAX_STAGES = 24;

  // fraction bits of the x/y datapath
  localparam int FRAC_BITS = 8;

  // bits above the coordinate width: difference sign, fraction, CORDIC growth
  localparam int GUARD_BITS = 12;

  localparam int ANGLE_W = 32;
  localparam int DIST_W  = 16;
  localparam int BEAR_W  = 16;
  localparam int GAIN_W  = 30;

  // low slice of the magnitude for the split gain multiply
  localparam int MUL_LO_W = 18;

  // 1/K in Q30
  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;

  // half a turn, 2^32 units per turn
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [ANGLE_W-1:0] atan_step(input int unsigned idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hdl/vdb_prep.sv
// ----------------------------------------------------------------------------
// vdb_prep: difference vector and half-plane fold
// Forms dx, dy, folds the left half-plane onto the right and scales to fixed point.
// ----------------------------------------------------------------------------
module vdb_prep #(
  parameter int COORD_WIDTH = vdb_pkg::COORD_WIDTH_DEFAULT,
  localparam int XW = COORD_WIDTH + vdb_pkg::GUARD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] own_x,
  input  logic signed [COORD_WIDTH-1:0] own_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic [vdb_pkg::ANGLE_W-1:0]   z_out,
  output logic                          zero_out
);

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic signed [COORD_WIDTH:0] fx;
  logic signed [COORD_WIDTH:0] fy;
  logic                        left;

  // one extra bit holds the full difference range
  assign dx   = {target_x[COORD_WIDTH-1], target_x} - {own_x[COORD_WIDTH-1], own_x};
  assign dy   = {target_y[COORD_WIDTH-1], target_y} - {own_y[COORD_WIDTH-1], own_y};

  assign left = dx[COORD_WIDTH];
  assign fx   = left ? -dx : dx;
  assign fy   = left ? -dy : dy;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_out    <= XW'(fx) <<< vdb_pkg::FRAC_BITS;
      y_out    <= XW'(fy) <<< vdb_pkg::FRAC_BITS;
      z_out    <= left ? vdb_pkg::HALF_TURN : '0;
      zero_out <= (dx == '0) && (dy == '0);
    end
  end

endmodule

### hdl/vdb_cordic_stage.sv
// ----------------------------------------------------------------------------
// vdb_cordic_stage: one CORDIC vectoring iteration
// Rotates toward the x axis by atan(2^-STAGE) and accumulates the angle.
// ----------------------------------------------------------------------------
module vdb_cordic_stage #(
  parameter int COORD_WIDTH = vdb_pkg::COORD_WIDTH_DEFAULT,
  parameter int STAGE       = 0,
  localparam int XW = COORD_WIDTH + vdb_pkg::GUARD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [XW-1:0]        x_in,
  input  logic signed [XW-1:0]        y_in,
  input  logic [vdb_pkg::ANGLE_W-1:0] z_in,
  input  logic                        zero_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [XW-1:0]        x_out,
  output logic signed [XW-1:0]        y_out,
  output logic [vdb_pkg::ANGLE_W-1:0] z_out,
  output logic                        zero_out
);

  localparam logic [vdb_pkg::ANGLE_W-1:0] ATAN = vdb_pkg::atan_step(STAGE);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  // arithmetic shift is a floor shift
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      zero_out <= zero_in;
      if (!y_in[XW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

### hdl/vdb_scale.sv
// ----------------------------------------------------------------------------
// vdb_scale: gain removal and output rounding
// Split multiply by the inverse CORDIC gain, then rounds distance and bearing.
// ----------------------------------------------------------------------------
module vdb_scale #(
  parameter int COORD_WIDTH = vdb_pkg::COORD_WIDTH_DEFAULT,
  parameter int ITERATIONS  = vdb_pkg::ITERATIONS_DEFAULT,
  localparam int XW = COORD_WIDTH + vdb_pkg::GUARD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [XW-1:0]        x_in,
  input  logic [vdb_pkg::ANGLE_W-1:0] z_in,
  input  logic                        zero_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vdb_pkg::DIST_W-1:0]  distance,
  output logic [vdb_pkg::BEAR_W-1:0]  bearing
);

  localparam int LW = vdb_pkg::MUL_LO_W;
  localparam int HW = XW - LW;
  localparam int GW = vdb_pkg::GAIN_W;
  localparam int PW = XW + GW;
  localparam int SH = vdb_pkg::FRAC_BITS + 30;

  // inverse gain with the finite-stage correction
  localparam longint unsigned GAIN_DEN = 64'd3 << (2 * ITERATIONS);
  localparam longint unsigned GAIN_FIX = vdb_pkg::INV_GAIN_Q30
      + (2 * vdb_pkg::INV_GAIN_Q30 + (GAIN_DEN >> 1)) / GAIN_DEN;
  localparam logic [GW-1:0] GAIN = GAIN_FIX[GW-1:0];

  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (SH - 1);
  localparam logic [PW-1:0] DIST_MAX   = PW'({vdb_pkg::DIST_W{1'b1}});

  logic                        mul_valid;
  logic                        mul_ready;
  logic [LW+GW-1:0]            p_lo;
  logic [HW+GW-1:0]            p_hi;
  logic [vdb_pkg::ANGLE_W-1:0] mul_z;
  logic                        mul_zero;

  logic [XW-1:0]               xc;
  logic [PW-1:0]               sum;
  logic [PW-1:0]               q;
  logic [vdb_pkg::ANGLE_W-1:0] z_round;

  assign xc = x_in[XW-1] ? '0 : x_in;

  // multiply stage
  assign in_ready = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_lo     <= (LW+GW)'(xc[LW-1:0]) * (LW+GW)'(GAIN);
      p_hi     <= (HW+GW)'(xc[XW-1:LW]) * (HW+GW)'(GAIN);
      mul_z    <= z_in;
      mul_zero <= zero_in;
    end
  end

  // sum, round and saturate
  assign sum     = (PW'(p_hi) << LW) + PW'(p_lo) + ROUND_HALF;
  assign q       = sum >> SH;
  assign z_round = mul_z + vdb_pkg::ANGLE_W'(32'h8000);

  assign mul_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && mul_ready) begin
      if (mul_zero) begin
        distance <= '0;
        bearing  <= '0;
      end else begin
        distance <= (q > DIST_MAX) ? {vdb_pkg::DIST_W{1'b1}} : q[vdb_pkg::DIST_W-1:0];
        bearing  <= z_round[vdb_pkg::ANGLE_W-1 -: vdb_pkg::BEAR_W];
      end
    end
  end

endmodule

### hdl/vector_distance_and_bearing_top.sv
// ----------------------------------------------------------------------------
// vector_distance_and_bearing_top: distance and bearing between two points
// Pipelined CORDIC vectoring of the difference vector with gain compensation.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_ready   own_x, own_y, target_x, target_y
//  output   out_valid / out_ready distance, bearing
//
//  one request enters per cycle while in_ready is high; the registers in order:
//  one fold stage, one register per CORDIC iteration, multiply and round stages
//  every stage holds its own valid bit and advances when it is empty or the next
//  stage takes its data, so bubbles close up while the output is stalled
//  reset clears the valid bits only; the data registers keep their state
// ----------------------------------------------------------------------------
module vector_distance_and_bearing_top #(
  parameter int ITERATIONS  = vdb_pkg::ITERATIONS_DEFAULT,
  parameter int COORD_WIDTH = vdb_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_WIDTH-1:0] own_x,
  input  logic signed [COORD_WIDTH-1:0] own_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vdb_pkg::DIST_W-1:0]   distance,
  output logic [vdb_pkg::BEAR_W-1:0]   bearing
);

  localparam int XW = COORD_WIDTH + vdb_pkg::GUARD_BITS;
  localparam int N  = (ITERATIONS > vdb_pkg::MAX_STAGES) ? vdb_pkg::MAX_STAGES : ITERATIONS;

  logic                        cv    [0:N];
  logic                        cr    [0:N];
  logic signed [XW-1:0]        cx    [0:N];
  logic signed [XW-1:0]        cy    [0:N];
  logic [vdb_pkg::ANGLE_W-1:0] cz    [0:N];
  logic                        czero [0:N];

  vdb_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .own_x    (own_x),
    .own_y    (own_y),
    .target_x (target_x),
    .target_y (target_y),
    .out_valid(cv[0]),
    .out_ready(cr[0]),
    .x_out    (cx[0]),
    .y_out    (cy[0]),
    .z_out    (cz[0]),
    .zero_out (czero[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_stage
    vdb_cordic_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .STAGE      (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[k]),
      .in_ready (cr[k]),
      .x_in     (cx[k]),
      .y_in     (cy[k]),
      .z_in     (cz[k]),
      .zero_in  (czero[k]),
      .out_valid(cv[k+1]),
      .out_ready(cr[k+1]),
      .x_out    (cx[k+1]),
      .y_out    (cy[k+1]),
      .z_out    (cz[k+1]),
      .zero_out (czero[k+1])
    );
  end

  // y of the last stage is not needed further on
  vdb_scale #(
    .COORD_WIDTH(COORD_WIDTH),
    .ITERATIONS (ITERATIONS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[N]),
    .in_ready (cr[N]),
    .x_in     (cx[N]),
    .z_in     (cz[N]),
    .zero_in  (czero[N]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .distance (distance),
    .bearing  (bearing)
  );

endmodule
